// File: design/hct_pkg.sv
// Shared types, constants and helpers for the handheld console timer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package hct_pkg;

  // Default divider period in machine clocks (a power of two, 16 to 1024).
  localparam int unsigned DivPeriodDefault = 256;

  localparam int unsigned CycW     = 8;   // elapsed clocks per word
  localparam int unsigned CntW     = 8;   // divider and timer counts
  localparam int unsigned TimResW  = 10;  // timer residue, below 1024
  localparam int unsigned TimSumW  = 11;  // residue plus one word of clocks
  localparam int unsigned TimIncW  = 7;   // counts per word, at most 1278 >> 4
  localparam int unsigned ShiftW   = 4;   // log2 of a timer period
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTimerEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegClockSelect = 2'd1;
  localparam logic [CfgIdxW-1:0] RegReloadValue = 2'd2;

  typedef enum logic [1:0] {
    SelP1024 = 2'd0,
    SelP16   = 2'd1,
    SelP64   = 2'd2,
    SelP256  = 2'd3
  } clk_sel_e;

  typedef struct packed {
    logic            timer_enable;
    clk_sel_e        clock_select;
    logic [CntW-1:0] reload_value;
  } cfg_t;

  // Input register contents handed to the counter stage
  typedef struct packed {
    logic            valid;
    logic [CycW-1:0] cycles;
  } stage_t;

  typedef struct packed {
    logic [CntW-1:0] divider_value;
    logic [CntW-1:0] timer_value;
    logic            timer_irq;
  } result_t;

  function automatic logic [ShiftW-1:0] period_shift(clk_sel_e sel);
    logic [ShiftW-1:0] sh;
    case (sel)
      SelP16:   sh = 4'd4;
      SelP64:   sh = 4'd6;
      SelP256:  sh = 4'd8;
      SelP1024: sh = 4'd10;
      default:  sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

// File: design/hct_ifs.sv
// Channel interfaces of the handheld console timer: input, result, config.
// Depends on hct_pkg for widths.
`default_nettype none

interface hct_in_if;
  logic                      valid;
  logic                      ready;
  logic [hct_pkg::CycW-1:0]  elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface hct_out_if;
  logic                      valid;
  logic                      ready;
  logic [hct_pkg::CntW-1:0]  divider_value;
  logic [hct_pkg::CntW-1:0]  timer_value;
  logic                      timer_irq;

  modport source (output valid, output divider_value, output timer_value,
                  output timer_irq, input ready);
  modport sink   (input valid, input divider_value, input timer_value,
                  input timer_irq, output ready);
endinterface

interface hct_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [hct_pkg::CfgIdxW-1:0]  index;
  logic [hct_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/handheld_console_timer_core.sv
// Top level of the handheld console divider/timer block.
// Depends on hct_pkg, the hct_*_if interfaces, hct_cfg_regs, hct_in_reg and hct_count_core.
//
// Usage:
//   in_if  : one word per instruction, elapsed_cycles = machine clocks since the last word.
//   out_if : exactly one result word per input word, in order: divider_value,
//            timer_value and timer_irq (1 when the timer overflowed and reloaded).
//   cfg_if : index 0 timer_enable, 1 clock_select (a clk_sel_e code that picks the timer
//            period), 2 reload_value; other indexes are ignored. ready is always 1.
//            Write only while no word is in flight.
//   Path: a word accepted sits in the input register, moves to the result register when
//   the counter stage advances, and shows on out_if right after it, where the sink can take it.
//   Throughput: one word per cycle while out_if.ready is high, set by the combinational
//   update of the counter stage (residue add, shift by the period, count add).
//   DivPeriod must be a power of two between 16 and 1024.
//   Stall: when out_if.ready is low the result register holds and the input register
//   still takes one more word; in_if.ready drops only once both are full.
//   Reset (rst_ni low, asynchronous): counters, residues and config go to zero,
//   both pipeline registers empty; there is no clearing pass.
`default_nettype none

module handheld_console_timer_core #(
  parameter int unsigned DivPeriod = hct_pkg::DivPeriodDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hct_in_if.sink     in_if,
  hct_out_if.source  out_if,
  hct_cfg_if.sink    cfg_if
);

  hct_pkg::cfg_t    cfg;
  hct_pkg::stage_t  stage;
  hct_pkg::result_t res;
  logic             advance;
  logic             res_valid;

  hct_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  hct_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_if.valid),
    .cycles_i  (in_if.elapsed_cycles),
    .advance_i (advance),
    .ready_o   (in_if.ready),
    .stage_o   (stage)
  );

  hct_count_core #(
    .DivPeriod (DivPeriod)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .cfg_i       (cfg),
    .out_ready_i (out_if.ready),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_if.valid         = res_valid;
  assign out_if.divider_value = res.divider_value;
  assign out_if.timer_value   = res.timer_value;
  assign out_if.timer_irq     = res.timer_irq;

endmodule

`default_nettype wire

// File: design/hct_cfg_regs.sv
// Configuration registers of the handheld console timer.
// Depends on hct_pkg and the hct_cfg_if interface.
`default_nettype none

module hct_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  hct_cfg_if.sink           cfg_if,
  output hct_pkg::cfg_t     cfg_o
);

  hct_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        hct_pkg::RegTimerEnable: cfg_d.timer_enable = cfg_if.data[0];
        hct_pkg::RegClockSelect: cfg_d.clock_select = hct_pkg::clk_sel_e'(cfg_if.data[1:0]);
        hct_pkg::RegReloadValue: cfg_d.reload_value = cfg_if.data[hct_pkg::CntW-1:0];
        default: ;  // no register there: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{timer_enable: 1'b0, clock_select: hct_pkg::SelP1024,
                 reload_value: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/hct_in_reg.sv
// Input register of the handheld console timer: holds one word of elapsed clocks.
// Depends on hct_pkg.
`default_nettype none

module hct_in_reg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [hct_pkg::CycW-1:0] cycles_i,
  input  wire logic                     advance_i,
  output logic                          ready_o,
  output hct_pkg::stage_t               stage_o
);

  logic                     valid_q;
  logic [hct_pkg::CycW-1:0] cycles_q;

  // Free slot, or the held word moves on this cycle
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cycles_q <= cycles_i;
    end
  end

  assign stage_o = '{valid: valid_q, cycles: cycles_q};

endmodule

`default_nettype wire

// File: design/hct_count_core.sv
// Divider and timer counters with residues, plus the result register.
// Depends on hct_pkg.
`default_nettype none

module hct_count_core #(
  parameter int unsigned DivPeriod = hct_pkg::DivPeriodDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hct_pkg::stage_t  stage_i,
  input  wire hct_pkg::cfg_t    cfg_i,
  input  wire logic             out_ready_i,
  output logic                  advance_o,
  output logic                  res_valid_o,
  output hct_pkg::result_t      res_o
);

  localparam int unsigned DivResW = $clog2(DivPeriod);
  localparam int unsigned DivSumW = ((DivResW > hct_pkg::CycW) ? DivResW : hct_pkg::CycW) + 1;

  logic [DivResW-1:0]          div_res_q, div_res_d;
  logic [hct_pkg::CntW-1:0]    div_cnt_q, div_cnt_d;
  logic [hct_pkg::TimResW-1:0] tim_res_q, tim_res_d;
  logic [hct_pkg::CntW-1:0]    tim_cnt_q, tim_cnt_d;
  logic                        res_valid_q;
  hct_pkg::result_t            res_q, res_d;

  logic [DivSumW-1:0]          div_sum;
  logic [hct_pkg::TimSumW-1:0] tim_sum;
  logic [hct_pkg::TimSumW-1:0] tim_mask;
  logic [hct_pkg::ShiftW-1:0]  tim_shift;
  logic [hct_pkg::TimIncW-1:0] tim_inc;
  logic [hct_pkg::CntW:0]      tim_next;
  logic                        irq;

  assign advance_o = !res_valid_q || out_ready_i;

  always_comb begin
    // Divider: period is a power of two, so count = sum >> log2, residue = low bits
    div_sum   = DivSumW'(div_res_q) + DivSumW'(stage_i.cycles);
    div_res_d = div_sum[DivResW-1:0];
    div_cnt_d = div_cnt_q + hct_pkg::CntW'(div_sum >> DivResW);

    tim_shift = hct_pkg::period_shift(cfg_i.clock_select);
    tim_sum   = hct_pkg::TimSumW'(tim_res_q) + hct_pkg::TimSumW'(stage_i.cycles);
    tim_mask  = (hct_pkg::TimSumW'(1) << tim_shift) - hct_pkg::TimSumW'(1);
    tim_inc   = hct_pkg::TimIncW'(tim_sum >> tim_shift);
    tim_next  = (hct_pkg::CntW+1)'(tim_cnt_q) + (hct_pkg::CntW+1)'(tim_inc);
    irq       = 1'b0;
    tim_res_d = tim_res_q;
    tim_cnt_d = tim_cnt_q;
    if (cfg_i.timer_enable) begin
      tim_res_d = hct_pkg::TimResW'(tim_sum & tim_mask);
      if (tim_next[hct_pkg::CntW]) begin
        tim_cnt_d = cfg_i.reload_value;
        irq       = 1'b1;
      end else begin
        tim_cnt_d = tim_next[hct_pkg::CntW-1:0];
      end
    end

    res_d = '{divider_value: div_cnt_d, timer_value: tim_cnt_d, timer_irq: irq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_res_q   <= '0;
      div_cnt_q   <= '0;
      tim_res_q   <= '0;
      tim_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else if (advance_o) begin
      res_valid_q <= stage_i.valid;
      if (stage_i.valid) begin
        div_res_q <= div_res_d;
        div_cnt_q <= div_cnt_d;
        tim_res_q <= tim_res_d;
        tim_cnt_q <= tim_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && stage_i.valid) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A held word in the input register always lands in the result register
  a_word_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && stage_i.valid |=> res_valid_q)
    else $error("input word did not reach the result register");

  // Disabled timer never raises an interrupt
  a_irq_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && stage_i.valid && !cfg_i.timer_enable |=> !res_q.timer_irq)
    else $error("timer interrupt while timer disabled");

  // Interrupt result carries the reload value
  a_irq_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && stage_i.valid && irq |=> res_q.timer_value == $past(cfg_i.reload_value))
    else $error("timer value after overflow is not the reload value");

  // Counters hold when no word moves
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance_o && stage_i.valid) |=> $stable(div_cnt_q) && $stable(tim_cnt_q))
    else $error("counter changed without a word");

endmodule

`default_nettype wire
